FILE: rtl/shnm_pkg.sv
package shnm_pkg;

  // Intermediate magnitudes are scaled to stay below 2^FIT_W before squaring.
  localparam int FIT_W      = 30;
  localparam int ROOT_W     = FIT_W + 1;
  localparam int RAD_W      = 2 * ROOT_W;
  localparam int GAIN_W     = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;
  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd256;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN        = 3'd0,
    CFG_INVERT_X    = 3'd1,
    CFG_INVERT_Y    = 3'd2,
    CFG_INVERT_Z    = 3'd3,
    CFG_ZERO_TO_ONE = 3'd4
  } cfg_reg_t;

  // Pipeline control shared by the arithmetic sub-pipelines.
  typedef struct packed {
    logic en;
    logic valid;
  } pipe_ctl_t;

endpackage

FILE: rtl/shnm_sqrt.sv
module shnm_sqrt #(
  parameter int SIDE_W = 1
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  shnm_pkg::pipe_ctl_t             ctl_i,
  input  logic [shnm_pkg::RAD_W-1:0]      rad_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic [shnm_pkg::ROOT_W-1:0]     root_o,
  output logic [SIDE_W-1:0]               side_o
);

  localparam int N  = shnm_pkg::ROOT_W;
  localparam int RW = shnm_pkg::RAD_W + 1;

  logic [RW-1:0]     v_r    [N];
  logic [RW-1:0]     r_r    [N];
  logic [SIDE_W-1:0] side_r [N];
  logic              val_r  [N];

  // One result bit per stage, most significant first.
  for (genvar k = 0; k < N; k++) begin : g_stage
    localparam logic [RW-1:0] B = RW'(1) << (2 * (N - 1 - k));
    logic [RW-1:0]     v_in, r_in, trial, v_nxt, r_nxt;
    logic [SIDE_W-1:0] side_in;
    logic              val_in;

    if (k == 0) begin : g_first
      assign v_in    = RW'(rad_i);
      assign r_in    = '0;
      assign side_in = side_i;
      assign val_in  = ctl_i.valid;
    end else begin : g_next
      assign v_in    = v_r[k-1];
      assign r_in    = r_r[k-1];
      assign side_in = side_r[k-1];
      assign val_in  = val_r[k-1];
    end

    assign trial = r_in + B;

    always_comb begin
      if (v_in >= trial) begin
        v_nxt = v_in - trial;
        r_nxt = (r_in >> 1) + B;
      end else begin
        v_nxt = v_in;
        r_nxt = r_in >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else if (ctl_i.en) begin
        val_r[k] <= val_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        v_r[k]    <= v_nxt;
        r_r[k]    <= r_nxt;
        side_r[k] <= side_in;
      end
    end
  end

  assign valid_o = val_r[N-1];
  assign root_o  = r_r[N-1][N-1:0];
  assign side_o  = side_r[N-1];

endmodule

FILE: rtl/shnm_div.sv
module shnm_div #(
  parameter int Q_W    = 15,
  parameter int N_W    = 45,
  parameter int SIDE_W = 2
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  shnm_pkg::pipe_ctl_t             ctl_i,
  input  logic [N_W-1:0]                  num_i [3],
  input  logic [shnm_pkg::ROOT_W-1:0]     den_i,
  input  logic [SIDE_W-1:0]               side_i,
  output logic                            valid_o,
  output logic [Q_W-1:0]                  quo_o [3],
  output logic [SIDE_W-1:0]               side_o
);

  localparam int D_W = shnm_pkg::ROOT_W;

  logic [D_W-1:0]    rem_r  [Q_W][3];
  logic [Q_W-1:0]    lo_r   [Q_W][3];
  logic [Q_W-1:0]    q_r    [Q_W][3];
  logic [D_W-1:0]    den_r  [Q_W];
  logic [SIDE_W-1:0] side_r [Q_W];
  logic              val_r  [Q_W];

  // Restoring division, one quotient bit per stage for all three lanes.
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [D_W-1:0]    den_in;
    logic [SIDE_W-1:0] side_in;
    logic              val_in;

    if (k == 0) begin : g_first
      assign den_in  = den_i;
      assign side_in = side_i;
      assign val_in  = ctl_i.valid;
    end else begin : g_next
      assign den_in  = den_r[k-1];
      assign side_in = side_r[k-1];
      assign val_in  = val_r[k-1];
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [D_W-1:0] rem_in, rem_nxt;
      logic [Q_W-1:0] lo_in, q_in;
      logic [D_W:0]   t, diff;
      logic           ge;

      if (k == 0) begin : g_first
        assign rem_in = {1'b0, num_i[l][N_W-1:Q_W]};
        assign lo_in  = num_i[l][Q_W-1:0];
        assign q_in   = '0;
      end else begin : g_next
        assign rem_in = rem_r[k-1][l];
        assign lo_in  = lo_r[k-1][l];
        assign q_in   = q_r[k-1][l];
      end

      assign t       = {rem_in, lo_in[Q_W-1-k]};
      assign diff    = t - {1'b0, den_in};
      assign ge      = t >= {1'b0, den_in};
      assign rem_nxt = ge ? diff[D_W-1:0] : t[D_W-1:0];

      always_ff @(posedge clk) begin
        if (ctl_i.en) begin
          rem_r[k][l] <= rem_nxt;
          lo_r[k][l]  <= lo_in;
          q_r[k][l]   <= {q_in[Q_W-2:0], ge};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        val_r[k] <= 1'b0;
      end else if (ctl_i.en) begin
        val_r[k] <= val_in;
      end
    end

    always_ff @(posedge clk) begin
      if (ctl_i.en) begin
        den_r[k]  <= den_in;
        side_r[k] <= side_in;
      end
    end
  end

  assign valid_o = val_r[Q_W-1];
  assign side_o  = side_r[Q_W-1];
  for (genvar l = 0; l < 3; l++) begin : g_out
    assign quo_o[l] = q_r[Q_W-1][l];
  end

endmodule

FILE: rtl/sobel_height_to_normal_top.sv
// Height map to surface normal converter.
// Input channel (in_valid/in_ready): one word holds the eight neighbor heights
// of one pixel. Output channel (out_valid/out_ready): one word holds the unit
// normal (normal_x, normal_y, normal_z) as signed Q1.OUT_FRAC_BITS values.
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes
// gain, the three invert flags and the zero-to-one remap; it is always ready.
// The user must write it only while no word is in flight; the block itself
// does not enforce this. Throughput is one word per clock while the skid is
// empty. The path has OUT_FRAC_BITS + 40 register stages: six front stages
// for Sobel sums, gain, magnitude, scaling, squares and their sum, 31
// square-root stages, one numerator stage, OUT_FRAC_BITS + 1 divider stages
// and the output register. When the receiver stalls, a one-word skid register
// catches the word that leaves the pipeline; while it is full the whole
// pipeline holds and in_ready is low. Nothing is lost or repeated. Reset
// clears all valid bits, empties the output and sets gain to 1.0, flags cleared.
module sobel_height_to_normal_top #(
  parameter int SAMPLE_BITS   = 16,
  parameter int OUT_FRAC_BITS = 14
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [SAMPLE_BITS-1:0]              in_up_left,
  input  logic [SAMPLE_BITS-1:0]              in_up_mid,
  input  logic [SAMPLE_BITS-1:0]              in_up_right,
  input  logic [SAMPLE_BITS-1:0]              in_mid_left,
  input  logic [SAMPLE_BITS-1:0]              in_mid_right,
  input  logic [SAMPLE_BITS-1:0]              in_down_left,
  input  logic [SAMPLE_BITS-1:0]              in_down_mid,
  input  logic [SAMPLE_BITS-1:0]              in_down_right,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [OUT_FRAC_BITS+1:0]     out_normal_x,
  output logic signed [OUT_FRAC_BITS+1:0]     out_normal_y,
  output logic signed [OUT_FRAC_BITS+1:0]     out_normal_z,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [shnm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [shnm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW     = SAMPLE_BITS;
  localparam int F      = OUT_FRAC_BITS;
  localparam int FIT_W  = shnm_pkg::FIT_W;
  localparam int GAIN_W = shnm_pkg::GAIN_W;
  localparam int SUM_W  = SW + 2;
  localparam int SX_W   = SW + 3;
  localparam int PROD_W = SX_W + GAIN_W + 1;
  localparam int GW     = SW + 17;
  localparam int WW     = (GW > FIT_W) ? GW : FIT_W + 1;
  localparam int SH_N   = WW - FIT_W;
  localparam int SH_W   = $clog2(SH_N + 1);
  localparam int SQ_W   = 2 * FIT_W;
  localparam int Q_W    = F + 1;
  localparam int N_W    = FIT_W + Q_W;
  localparam int O_W    = F + 2;
  localparam int SIDE_W = 2 + 3 * FIT_W;
  localparam logic [WW-1:0]  AZ_FULL = WW'(1) << (SW + 8);
  localparam logic [Q_W-1:0] ONE_Q   = Q_W'(1) << F;

  // Configuration registers.
  logic [GAIN_W-1:0] gain_r;
  logic inv_x_r, inv_y_r, inv_z_r, zero_to_one_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r        <= shnm_pkg::GAIN_RESET;
      inv_x_r       <= 1'b0;
      inv_y_r       <= 1'b0;
      inv_z_r       <= 1'b0;
      zero_to_one_r <= 1'b0;
    end else if (cfg_valid) begin
      case (shnm_pkg::cfg_reg_t'(cfg_index))
        shnm_pkg::CFG_GAIN:        gain_r        <= cfg_data[GAIN_W-1:0];
        shnm_pkg::CFG_INVERT_X:    inv_x_r       <= cfg_data[0];
        shnm_pkg::CFG_INVERT_Y:    inv_y_r       <= cfg_data[0];
        shnm_pkg::CFG_INVERT_Z:    inv_z_r       <= cfg_data[0];
        shnm_pkg::CFG_ZERO_TO_ONE: zero_to_one_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Global pipeline advance: the whole pipe holds only while the skid is full.
  logic skid_v_r, out_v_r, en;
  assign en       = !skid_v_r;
  assign in_ready = en;

  // Stage 1: Sobel column and row differences.
  logic [SUM_W-1:0] lsum, rsum, usum, dsum;
  logic signed [SX_W-1:0] s1_sx_r, s1_sy_r;
  logic s1_v_r;

  assign lsum = SUM_W'(in_up_left) + (SUM_W'(in_mid_left) << 1) + SUM_W'(in_down_left);
  assign rsum = SUM_W'(in_up_right) + (SUM_W'(in_mid_right) << 1) + SUM_W'(in_down_right);
  assign usum = SUM_W'(in_up_left) + (SUM_W'(in_up_mid) << 1) + SUM_W'(in_up_right);
  assign dsum = SUM_W'(in_down_left) + (SUM_W'(in_down_mid) << 1) + SUM_W'(in_down_right);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_sx_r <= $signed({1'b0, lsum}) - $signed({1'b0, rsum});
      s1_sy_r <= $signed({1'b0, usum}) - $signed({1'b0, dsum});
    end
  end

  // Stage 2: gain multiply.
  logic signed [PROD_W-1:0] s2_gx_r, s2_gy_r;
  logic signed [PROD_W-1:0] gain_s;
  logic s2_v_r;

  assign gain_s = PROD_W'($signed({1'b0, gain_r}));

  always_ff @(posedge clk) begin
    if (en) begin
      s2_gx_r <= PROD_W'(s1_sx_r) * gain_s;
      s2_gy_r <= PROD_W'(s1_sy_r) * gain_s;
    end
  end

  // Stage 3: magnitudes and signs.
  logic [PROD_W-1:0] gx_abs, gy_abs;
  logic [WW-1:0] s3_ax_r, s3_ay_r;
  logic s3_nx_r, s3_ny_r, s3_v_r;

  assign gx_abs = s2_gx_r[PROD_W-1] ? PROD_W'(-s2_gx_r) : PROD_W'(s2_gx_r);
  assign gy_abs = s2_gy_r[PROD_W-1] ? PROD_W'(-s2_gy_r) : PROD_W'(s2_gy_r);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_ax_r <= WW'(gx_abs[GW-1:0]);
      s3_ay_r <= WW'(gy_abs[GW-1:0]);
      s3_nx_r <= s2_gx_r[PROD_W-1];
      s3_ny_r <= s2_gy_r[PROD_W-1];
    end
  end

  // Stage 4: common right shift that brings the largest magnitude below 2^FIT_W.
  logic [SH_W-1:0] shamt;
  logic [FIT_W-1:0] s4_ax_r, s4_ay_r, s4_az_r;
  logic s4_nx_r, s4_ny_r, s4_v_r;

  always_comb begin
    shamt = '0;
    for (int k = 0; k < SH_N; k++) begin
      if (((s3_ax_r | s3_ay_r | AZ_FULL) >> (FIT_W + k)) != '0) begin
        shamt = shamt + SH_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_ax_r <= FIT_W'(s3_ax_r >> shamt);
      s4_ay_r <= FIT_W'(s3_ay_r >> shamt);
      s4_az_r <= FIT_W'(AZ_FULL >> shamt);
      s4_nx_r <= s3_nx_r;
      s4_ny_r <= s3_ny_r;
    end
  end

  // Stage 5: squares.
  logic [SQ_W-1:0] s5_qx_r, s5_qy_r, s5_qz_r;
  logic [FIT_W-1:0] s5_ax_r, s5_ay_r, s5_az_r;
  logic s5_nx_r, s5_ny_r, s5_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_qx_r <= SQ_W'(s4_ax_r) * SQ_W'(s4_ax_r);
      s5_qy_r <= SQ_W'(s4_ay_r) * SQ_W'(s4_ay_r);
      s5_qz_r <= SQ_W'(s4_az_r) * SQ_W'(s4_az_r);
      s5_ax_r <= s4_ax_r;
      s5_ay_r <= s4_ay_r;
      s5_az_r <= s4_az_r;
      s5_nx_r <= s4_nx_r;
      s5_ny_r <= s4_ny_r;
    end
  end

  // Stage 6: squared length.
  logic [shnm_pkg::RAD_W-1:0] s6_rad_r;
  logic [SIDE_W-1:0] s6_side_r;
  logic s6_v_r;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_rad_r  <= shnm_pkg::RAD_W'(s5_qx_r) + shnm_pkg::RAD_W'(s5_qy_r)
                 + shnm_pkg::RAD_W'(s5_qz_r);
      s6_side_r <= {s5_nx_r, s5_ny_r, s5_ax_r, s5_ay_r, s5_az_r};
    end
  end

  // Valid bits of the front stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
      s5_v_r <= s4_v_r;
      s6_v_r <= s5_v_r;
    end
  end

  // Square root of the squared length.
  logic sq_v;
  logic [shnm_pkg::ROOT_W-1:0] sq_root;
  logic [SIDE_W-1:0] sq_side;

  shnm_sqrt #(.SIDE_W(SIDE_W)) u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   ('{en: en, valid: s6_v_r}),
    .rad_i   (s6_rad_r),
    .side_i  (s6_side_r),
    .valid_o (sq_v),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // Stage 7: rounded numerators a * 2^F + L/2.
  logic [FIT_W-1:0] sq_ax, sq_ay, sq_az;
  logic [N_W-1:0] half_len;
  logic [N_W-1:0] s7_num_r [3];
  logic [shnm_pkg::ROOT_W-1:0] s7_len_r;
  logic [1:0] s7_sign_r;
  logic s7_v_r;

  assign sq_ax    = sq_side[3*FIT_W-1:2*FIT_W];
  assign sq_ay    = sq_side[2*FIT_W-1:FIT_W];
  assign sq_az    = sq_side[FIT_W-1:0];
  assign half_len = N_W'(sq_root >> 1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (en) begin
      s7_v_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_num_r[0] <= (N_W'(sq_ax) << F) + half_len;
      s7_num_r[1] <= (N_W'(sq_ay) << F) + half_len;
      s7_num_r[2] <= (N_W'(sq_az) << F) + half_len;
      s7_len_r    <= sq_root;
      s7_sign_r   <= sq_side[SIDE_W-1:SIDE_W-2];
    end
  end

  // Division by the length, three lanes.
  logic dv_v;
  logic [Q_W-1:0] dv_q [3];
  logic [1:0] dv_sign;

  shnm_div #(.Q_W(Q_W), .N_W(N_W), .SIDE_W(2)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctl_i   ('{en: en, valid: s7_v_r}),
    .num_i   (s7_num_r),
    .den_i   (s7_len_r),
    .side_i  (s7_sign_r),
    .valid_o (dv_v),
    .quo_o   (dv_q),
    .side_o  (dv_sign)
  );

  // Saturation, sign, inversion and optional remap to zero..one.
  function automatic logic [O_W-1:0] finish(input logic [Q_W-1:0] q, input logic neg,
                                            input logic z1);
    logic [Q_W-1:0] m;
    logic signed [O_W:0] t;
    logic signed [O_W:0] u;
    m = (q > ONE_Q) ? ONE_Q : q;
    t = neg ? -$signed({2'b00, m}) : $signed({2'b00, m});
    u = t + $signed((O_W + 1)'(ONE_Q) + (O_W + 1)'(1));
    if (z1) begin
      finish = O_W'(u >>> 1);
    end else begin
      finish = t[O_W-1:0];
    end
  endfunction

  logic [O_W-1:0] fin_x, fin_y, fin_z;
  assign fin_x = finish(dv_q[0], dv_sign[1] ^ inv_x_r, zero_to_one_r);
  assign fin_y = finish(dv_q[1], dv_sign[0] ^ inv_y_r, zero_to_one_r);
  assign fin_z = finish(dv_q[2], inv_z_r, zero_to_one_r);

  // Output register with a one-word skid.
  logic [O_W-1:0] out_x_r, out_y_r, out_z_r, skid_x_r, skid_y_r, skid_z_r;
  logic out_free;
  assign out_free = !out_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r  <= skid_v_r || (en && dv_v);
      skid_v_r <= 1'b0;
    end else if (en && dv_v) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_v_r) begin
        out_x_r <= skid_x_r;
        out_y_r <= skid_y_r;
        out_z_r <= skid_z_r;
      end else begin
        out_x_r <= fin_x;
        out_y_r <= fin_y;
        out_z_r <= fin_z;
      end
    end else if (en && dv_v) begin
      skid_x_r <= fin_x;
      skid_y_r <= fin_y;
      skid_z_r <= fin_z;
    end
  end

  assign out_valid    = out_v_r;
  assign out_normal_x = $signed(out_x_r);
  assign out_normal_y = $signed(out_y_r);
  assign out_normal_z = $signed(out_z_r);

  // The skid only ever holds a word behind a waiting output word.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r |-> out_v_r)
    else $error("skid holds a word while the output is empty");

  // A word leaving the pipe while the output stalls must land in the skid.
  a_skid_catches: assert property (@(posedge clk) disable iff (!rst_n)
    (en && dv_v && out_v_r && !out_ready) |=> skid_v_r)
    else $error("word from the pipeline was dropped");

  // The length is never zero because the z part is never zero.
  a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    s7_v_r |-> (s7_len_r != '0))
    else $error("zero length reached the divider");

  // Without the remap, every component stays within plus or minus one; the check covers normal_x.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !zero_to_one_r) |->
      ($signed(out_x_r) <= $signed(O_W'(ONE_Q)) && $signed(out_x_r) >= -$signed(O_W'(ONE_Q))))
    else $error("normal_x out of range");

endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int SB = 16;
  localparam int OF = 14;
  localparam int OW = OF + 2;
  localparam int LATENCY = OF + 40;
  localparam int N_RANDOM = 600;
  localparam longint CYCLE_LIMIT = 400000;

  typedef struct {
    logic [SB-1:0] h [8];
  } window_t;

  typedef struct {
    logic [OW-1:0] nx;
    logic [OW-1:0] ny;
    logic [OW-1:0] nz;
  } normal_t;

  // One row of the directed table: a config write or a pixel window.
  typedef struct {
    bit is_cfg;
    shnm_pkg::cfg_reg_t idx;
    logic [shnm_pkg::CFG_DATA_W-1:0] data;
    window_t win;
    bit has_known;
    normal_t known;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [SB-1:0] in_h [8];
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [OW-1:0] out_normal_x, out_normal_y, out_normal_z;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [shnm_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [shnm_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor copy of the registers.
  logic [shnm_pkg::GAIN_W-1:0] mdl_gain;
  bit mdl_inv_x, mdl_inv_y, mdl_inv_z, mdl_z2o;

  normal_t normal_q[$];
  int errors = 0;
  longint cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit long_hold = 0;

  initial for (int i = 0; i < 8; i++) in_h[i] = '0;

  always #2 clk = ~clk;

  sobel_height_to_normal_top u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_up_left(in_h[0]), .in_up_mid(in_h[1]), .in_up_right(in_h[2]),
    .in_mid_left(in_h[3]), .in_mid_right(in_h[4]),
    .in_down_left(in_h[5]), .in_down_mid(in_h[6]), .in_down_right(in_h[7]),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_normal_x(out_normal_x), .out_normal_y(out_normal_y),
    .out_normal_z(out_normal_z),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Scales one magnitude to a rounded, saturated, signed Q1.14 component, then applies the zero-to-one remap if set.
  function automatic logic [OW-1:0] to_component(longint unsigned mag, bit neg,
                                                 longint unsigned len, bit inv);
    longint unsigned n;
    n = ((mag << OF) + (len >> 1)) / len;
    if (n > (64'd1 << OF)) n = 64'd1 << OF;
    if (neg != inv) n = 64'd0 - n;
    if (mdl_z2o) n = (n + (64'd1 << OF) + 1) >> 1;
    return n[OW-1:0];
  endfunction

  function automatic normal_t sobel_normal(window_t w);
    longint sx, sy, gx, gy;
    longint unsigned ax, ay, az, big, len;
    int sh;
    normal_t r;
    sx = (longint'(w.h[0]) + 2 * longint'(w.h[3]) + longint'(w.h[5]))
       - (longint'(w.h[2]) + 2 * longint'(w.h[4]) + longint'(w.h[7]));
    sy = (longint'(w.h[0]) + 2 * longint'(w.h[1]) + longint'(w.h[2]))
       - (longint'(w.h[5]) + 2 * longint'(w.h[6]) + longint'(w.h[7]));
    gx = sx * longint'(mdl_gain);
    gy = sy * longint'(mdl_gain);
    ax = gx < 0 ? -gx : gx;
    ay = gy < 0 ? -gy : gy;
    az = 64'd1 << (SB + 8);
    big = ax > ay ? ax : ay;
    if (az > big) big = az;
    sh = 0;
    while ((big >> sh) >= (64'd1 << shnm_pkg::FIT_W)) sh++;
    ax >>= sh;
    ay >>= sh;
    az >>= sh;
    len = int_sqrt(ax * ax + ay * ay + az * az);
    if (len == 0) len = 1;
    r.nx = to_component(ax, gx < 0, len, mdl_inv_x);
    r.ny = to_component(ay, gy < 0, len, mdl_inv_y);
    r.nz = to_component(az, 1'b0, len, mdl_inv_z);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [OW-1:0] got, logic [OW-1:0] want);
    $display("MISMATCH %s: got %0d expected %0d", what, $signed(got), $signed(want));
    errors++;
  endtask

  // Cycle counter and timeout.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("sobel_height_to_normal_top verification failed");
      $finish;
    end
  end

  // Receiver: random stalls plus one long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (long_hold) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker.
  always @(posedge clk) begin
    normal_t e;
    if (rst_n && out_valid && out_ready) begin
      if (normal_q.size() == 0) begin
        report_mismatch("unexpected word", out_normal_x, '0);
      end else begin
        e = normal_q.pop_front();
        if (out_normal_x !== e.nx) report_mismatch("normal_x", out_normal_x, e.nx);
        if (out_normal_y !== e.ny) report_mismatch("normal_y", out_normal_y, e.ny);
        if (out_normal_z !== e.nz) report_mismatch("normal_z", out_normal_z, e.nz);
      end
    end
  end

  task automatic drain();
    while (normal_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_reg(shnm_pkg::cfg_reg_t idx, logic [shnm_pkg::CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      shnm_pkg::CFG_GAIN: mdl_gain = val[shnm_pkg::GAIN_W-1:0];
      shnm_pkg::CFG_INVERT_X: mdl_inv_x = val[0];
      shnm_pkg::CFG_INVERT_Y: mdl_inv_y = val[0];
      shnm_pkg::CFG_INVERT_Z: mdl_inv_z = val[0];
      shnm_pkg::CFG_ZERO_TO_ONE: mdl_z2o = val[0];
      default: ;
    endcase
  endtask

  // Sends one word; valid stays high across back-to-back words.
  task automatic send_window(window_t w);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    for (int i = 0; i < 8; i++) in_h[i] <= w.h[i];
    do @(posedge clk); while (!in_ready);
    normal_q.push_back(sobel_normal(w));
  endtask

  function automatic window_t rand_window(int mode);
    window_t w;
    logic [SB-1:0] base;
    base = SB'($urandom);
    for (int i = 0; i < 8; i++) begin
      case (mode)
        0: w.h[i] = SB'($urandom);
        1: w.h[i] = SB'(base + $urandom_range(255) - 128);
        default: w.h[i] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      endcase
    end
    return w;
  endfunction

  function automatic window_t fill(logic [SB-1:0] a, logic [SB-1:0] b);
    window_t w;
    // Left column and top row take a, the rest b.
    w.h[0] = a; w.h[1] = a; w.h[2] = a; w.h[3] = a;
    w.h[4] = b; w.h[5] = a; w.h[6] = b; w.h[7] = b;
    return w;
  endfunction

  initial begin
    dir_row_t rows[$];
    dir_row_t r;
    normal_t flat;
    int phase_idle[4] = '{0, 87, 0, 87};
    int phase_stall[4] = '{0, 0, 87, 87};
    int pct;

    mdl_gain = shnm_pkg::GAIN_RESET;
    mdl_inv_x = 0; mdl_inv_y = 0; mdl_inv_z = 0; mdl_z2o = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. A flat window gives (0,0,1) whatever the gain.
    flat.nx = '0; flat.ny = '0; flat.nz = 16'd16384;
    r.is_cfg = 0;
    r.idx = shnm_pkg::CFG_GAIN;
    r.data = '0;
    r.has_known = 0;
    r.known = flat;
    r.win = fill(16'h0000, 16'h0000); r.has_known = 1; r.known = flat; rows.push_back(r);
    r.win = fill(16'hFFFF, 16'hFFFF); rows.push_back(r);
    r.has_known = 0;
    r.win = fill(16'hFFFF, 16'h0000); rows.push_back(r);
    r.win = fill(16'h0000, 16'hFFFF); rows.push_back(r);
    r.win = fill(16'h5555, 16'hAAAA); rows.push_back(r);
    r.win = fill(16'h0001, 16'h0000); rows.push_back(r);
    r.is_cfg = 1; r.idx = shnm_pkg::CFG_GAIN; r.data = 15'h7FFF; rows.push_back(r);
    r.is_cfg = 0; r.win = fill(16'hFFFF, 16'h0000); rows.push_back(r);
    r.win = fill(16'h0000, 16'h0001); rows.push_back(r);
    r.is_cfg = 1; r.idx = shnm_pkg::CFG_GAIN; r.data = 15'd0; rows.push_back(r);
    r.is_cfg = 0; r.win = fill(16'hFFFF, 16'h0000);
    r.has_known = 1; r.known = flat; rows.push_back(r);
    r.has_known = 0;
    r.is_cfg = 1; r.idx = shnm_pkg::CFG_GAIN; r.data = 15'd26; rows.push_back(r);
    r.idx = shnm_pkg::CFG_INVERT_X; r.data = 15'd1; rows.push_back(r);
    r.idx = shnm_pkg::CFG_INVERT_Y; r.data = 15'd1; rows.push_back(r);
    r.idx = shnm_pkg::CFG_INVERT_Z; r.data = 15'd1; rows.push_back(r);
    r.is_cfg = 0; r.win = fill(16'hFFFF, 16'h0000); rows.push_back(r);
    r.is_cfg = 1; r.idx = shnm_pkg::CFG_ZERO_TO_ONE; r.data = 15'd1; rows.push_back(r);
    r.is_cfg = 0; r.win = fill(16'h0000, 16'hFFFF); rows.push_back(r);
    r.win = fill(16'h0000, 16'h0000); rows.push_back(r);
    r.is_cfg = 1; r.idx = shnm_pkg::CFG_GAIN; r.data = 15'd25600; rows.push_back(r);
    r.is_cfg = 0; r.win = fill(16'h1234, 16'h0FED); rows.push_back(r);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) begin
        in_valid <= 1'b0;
        drain();
        write_reg(rows[i].idx, rows[i].data);
      end else begin
        send_window(rows[i].win);
        if (rows[i].has_known) normal_q[$] = rows[i].known;
      end
    end
    in_valid <= 1'b0;
    drain();

    // Random phases, each under a fresh register setting.
    for (int ph = 0; ph < 8; ph++) begin
      pct = ph % 4;
      send_idle_pct = phase_idle[pct];
      recv_stall_pct = phase_stall[pct];
      if (ph == 7) begin
        send_idle_pct = 7;
        recv_stall_pct = 7;
      end
      write_reg(shnm_pkg::CFG_GAIN, ph == 0 ? 15'd256 : ph == 1 ? 15'd25600 :
                ph == 2 ? 15'd26 : shnm_pkg::CFG_DATA_W'($urandom));
      write_reg(shnm_pkg::CFG_INVERT_X, shnm_pkg::CFG_DATA_W'($urandom));
      write_reg(shnm_pkg::CFG_INVERT_Y, shnm_pkg::CFG_DATA_W'($urandom));
      write_reg(shnm_pkg::CFG_INVERT_Z, shnm_pkg::CFG_DATA_W'($urandom));
      write_reg(shnm_pkg::CFG_ZERO_TO_ONE, shnm_pkg::CFG_DATA_W'($urandom));
      // The sender never idles here, so the hold-off fills the pipeline.
      if (ph == 2) begin
        fork
          begin
            long_hold = 1;
            repeat (300) @(posedge clk);
            long_hold = 0;
          end
        join_none
      end
      for (int k = 0; k < N_RANDOM / 8; k++)
        send_window(rand_window($urandom_range(9) < 6 ? 0 : $urandom_range(1, 2)));
      in_valid <= 1'b0;
      drain();
    end

    if (errors == 0) begin
      $display("sobel_height_to_normal_top verification clean");
    end else begin
      $display("sobel_height_to_normal_top verification failed");
    end
    $finish;
  end

endmodule

FILE: sobel_height_to_normal_top.f
rtl/shnm_pkg.sv
rtl/shnm_sqrt.sv
rtl/shnm_div.sv
rtl/sobel_height_to_normal_top.sv
tb/sv/tb_top.sv
